// ===== src/u8u16_pkg.sv =====
// Shared types, constants and the code point encoder of the UTF-8 to UTF-16LE transcoder.
package u8u16_pkg;

    localparam logic [20:0] RplChar   = 21'h00FFFD;
    localparam logic [20:0] MaxCp     = 21'h10FFFF;
    localparam logic [20:0] BmpMax    = 21'h00FFFF;
    localparam logic [20:0] SuppBase  = 21'h010000;
    localparam logic [5:0]  HiSurTag  = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  LoSurTag  = 6'b110111;   // 0xDC00 >> 10

    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Tag  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Tag  = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Tag  = 8'hF0;

    // Work handed from the decoder to the byte emitter.
    typedef struct packed {
        logic [1:0]  n_units;   // 0, 1 or 2 code units
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        term;      // append the 0x0000 terminator
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [1:0]  n_units;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } units_t;

    function automatic units_t encode_cp(input logic [20:0] cp);
        logic [20:0] c;
        logic [20:0] v;
        units_t      r;
        c = (cp > MaxCp) ? RplChar : cp;
        v = c - SuppBase;
        if (c <= BmpMax)
        begin
            r.n_units = 2'd1;
            r.unit0   = c[15:0];
            r.unit1   = 16'h0000;
        end
        else
        begin
            r.n_units = 2'd2;
            r.unit0   = {HiSurTag, v[19:10]};
            r.unit1   = {LoSurTag, v[9:0]};
        end
        return r;
    endfunction

endpackage

// ===== src/u8u16_front.sv =====
// Decoder front: accepts UTF-8 words, tracks sequence state and builds output jobs.
module u8u16_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        text_byte,
    input  logic [1:0]        following_bytes,
    input  logic              empty_string,
    input  logic              q_full,
    output logic              in_ready,
    output logic              push,
    output u8u16_pkg::job_t   job
);

    logic [1:0]  pend_reg, pend_next;
    logic [20:0] acc_reg, acc_next;
    logic        drop_reg, drop_next;

    logic        emit;
    logic        term;
    logic [20:0] emit_cp;
    logic [20:0] acc_shift;
    logic [1:0]  pend_dec;
    logic [1:0]  need;
    logic [20:0] lead_cp;
    logic        last_byte;
    logic        accept;
    u8u16_pkg::units_t enc;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign last_byte = (following_bytes == 2'd0);
    assign acc_shift = {acc_reg[14:0], text_byte[5:0]};
    assign pend_dec  = pend_reg - 2'd1;

    always_comb
    begin
        need    = 2'd0;
        lead_cp = u8u16_pkg::RplChar;
        priority if (text_byte[7] == 1'b0)
        begin
            lead_cp = {13'd0, text_byte};
        end
        else if ((text_byte & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Tag)
        begin
            lead_cp = {16'd0, text_byte[4:0]};
            need    = 2'd1;
        end
        else if ((text_byte & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Tag)
        begin
            lead_cp = {17'd0, text_byte[3:0]};
            need    = 2'd2;
        end
        else if ((text_byte & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Tag)
        begin
            lead_cp = {18'd0, text_byte[2:0]};
            need    = 2'd3;
        end
        else
        begin
            lead_cp = u8u16_pkg::RplChar;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        drop_next = drop_reg;
        emit      = 1'b0;
        term      = 1'b0;
        emit_cp   = u8u16_pkg::RplChar;
        priority if (empty_string)
        begin
            term = 1'b1;
        end
        else if (drop_reg)
        begin
            term = last_byte;
        end
        else if (pend_reg != 2'd0)
        begin
            if ((text_byte & u8u16_pkg::ContMask) != u8u16_pkg::ContTag)
            begin
                pend_next = 2'd0;
                acc_next  = 21'd0;
                emit      = 1'b1;
            end
            else
            begin
                pend_next = pend_dec;
                acc_next  = acc_shift;
                if (pend_dec == 2'd0)
                begin
                    emit     = 1'b1;
                    emit_cp  = acc_shift;
                    acc_next = 21'd0;
                end
                else if (last_byte)
                begin
                    emit = 1'b1;
                end
            end
            term = last_byte;
        end
        else
        begin
            priority if (need > following_bytes)
            begin
                // sequence runs past the string end: one replacement, drop the rest
                emit = 1'b1;
                if (last_byte)
                    term = 1'b1;
                else
                    drop_next = 1'b1;
            end
            else if (need != 2'd0)
            begin
                acc_next  = lead_cp;
                pend_next = need;
            end
            else
            begin
                emit    = 1'b1;
                emit_cp = lead_cp;
                term    = last_byte;
            end
        end
        if (term)
        begin
            pend_next = 2'd0;
            acc_next  = 21'd0;
            drop_next = 1'b0;
        end
    end

    assign enc         = u8u16_pkg::encode_cp(emit_cp);
    assign job.n_units = emit ? enc.n_units : 2'd0;
    assign job.unit0   = enc.unit0;
    assign job.unit1   = enc.unit1;
    assign job.term    = term;
    assign push        = accept && (emit || term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            acc_reg  <= 21'd0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== src/u8u16_queue.sv =====
// Job queue between the decoder front and the byte emitter.
module u8u16_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8u16_pkg::job_t     push_job,
    input  logic                pop,
    output u8u16_pkg::job_t     head,
    output u8u16_pkg::q_stat_t  stat
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    u8u16_pkg::job_t slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CntW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/u8u16_back.sv =====
// Byte emitter: walks the head job one byte at a time into the output register.
module u8u16_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8u16_pkg::job_t     head,
    input  u8u16_pkg::q_stat_t  stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          utf16_byte,
    output logic                run_last,
    output logic                string_done
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic [2:0] idx_reg, idx_next;

    logic       load;
    logic [2:0] total;
    logic [1:0] unit_idx;
    logic [15:0] unit_sel;

    assign load     = !valid_reg || out_ready;
    assign total    = {head.n_units, 1'b0} + {1'b0, head.term, 1'b0};
    assign unit_idx = idx_reg[2:1];
    assign unit_sel = (unit_idx == 2'd0) ? head.unit0 : head.unit1;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !stat.empty;
            if (!stat.empty)
            begin
                if (unit_idx < head.n_units)
                begin
                    byte_next = idx_reg[0] ? unit_sel[15:8] : unit_sel[7:0];
                    done_next = 1'b0;
                end
                else
                begin
                    byte_next = 8'h00;
                    done_next = idx_reg[0];
                end
                last_next = (idx_reg == total - 3'd1);
                if (last_next)
                begin
                    pop      = 1'b1;
                    idx_next = 3'd0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign out_valid   = valid_reg;
    assign utf16_byte  = byte_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

endmodule

// ===== src/utf8_to_utf16le_transcoder_unit.sv =====
// UTF-8 to UTF-16LE transcoder: top level.
//
// Input stream (s_*): one UTF-8 byte per word. s_tdata carries the byte and
// the count of bytes still to follow in the string (saturated at 3, zero on
// the last byte); s_tuser marks an empty string that carries no byte.
// Output stream (m_*): UTF-16LE bytes, low byte first. m_tlast closes the
// bytes caused by one input word, m_tuser flags the second byte of the
// closing 0x0000 terminator. Words that only open or continue a sequence
// produce no output.
// A word yields 0 to 6 output bytes, and the emitter sends one byte per
// cycle while the queue holds a job and m_tready does not stall it; a
// 4-byte sequence plus terminator yields six output bytes.
// The front takes a word whenever the job queue (QUEUE_DEPTH entries) has
// room, so it keeps decoding while the receiver stalls until the queue fills.
// Reset clears decoder state, the queue pointers and the output valid flag;
// s_tready is high out of reset, as the queue then starts empty.
module utf8_to_utf16le_transcoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] text_byte, [9:8] following_bytes, [15:10] zero
    input  logic        s_tuser,    // [0] empty_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] utf16_byte
    output logic        m_tlast,
    output logic        m_tuser     // [0] string_done
);

    logic               push;
    logic               pop;
    u8u16_pkg::job_t    push_job;
    u8u16_pkg::job_t    head;
    u8u16_pkg::q_stat_t stat;

    u8u16_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .text_byte       (s_tdata[7:0]),
        .following_bytes (s_tdata[9:8]),
        .empty_string    (s_tuser),
        .q_full          (stat.full),
        .in_ready        (s_tready),
        .push            (push),
        .job             (push_job)
    );

    u8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    u8u16_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .utf16_byte  (m_tdata),
        .run_last    (m_tlast),
        .string_done (m_tuser)
    );

`ifndef SYNTHESIS
    a_done_is_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("terminator byte not zero or not last");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("job queue popped while empty");

    a_stat_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("job queue both full and empty");

    a_push_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.n_units != 2'd0) || push_job.term)
        else $error("job pushed without output bytes");
`endif

endmodule
